// ===== hw/rtl/icpc_pkg.sv =====
package icpc_pkg;

  localparam int unsigned MaxNodes = 64;
  localparam int unsigned NodeW    = 6;
  localparam int unsigned NcW      = 7;
  localparam int unsigned PairW    = 11;

  typedef struct packed {
    logic [NodeW-1:0] node_a;
    logic [NodeW-1:0] node_b;
  } item_in_t;

  typedef struct packed {
    logic [PairW-1:0] disconnected_pairs;
    logic             bad_node;
  } item_out_t;

  typedef struct packed {
    logic             restart;
    logic [NcW-1:0]   node_count;
    logic [PairW-1:0] pair_init;
  } cfg_t;

  typedef enum logic [2:0] {
    StIdle,
    StRdB,
    StChk,
    StSweep,
    StMul,
    StUpd,
    StOut
  } state_e;

  function automatic logic [PairW-1:0] pair_total(input logic [NcW-1:0] nc);
    logic [2*NcW-1:0] prod;
    prod = nc * (nc - NcW'(1));
    return prod[PairW:1];
  endfunction

endpackage

// ===== hw/rtl/icpc_ram.sv =====
module icpc_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/icpc_core.sv =====
module icpc_core #(
  parameter int unsigned NODES = icpc_pkg::MaxNodes
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  icpc_pkg::cfg_t           cfg_i,
  input  logic                     in_valid_i,
  input  icpc_pkg::item_in_t       in_data_i,
  output logic                     in_stall_o,
  output logic                     res_valid_o,
  output icpc_pkg::item_out_t      res_o,
  input  logic                     res_free_i,
  output logic                     rd_en_o,
  output logic [$clog2(NODES)-1:0] rd_addr_o,
  input  logic [NODES-1:0]         rd_data_i,
  output logic                     wr_en_o,
  output logic [$clog2(NODES)-1:0] wr_addr_o,
  output logic [NODES-1:0]         wr_data_o
);
  import icpc_pkg::*;

  localparam int unsigned AW = $clog2(NODES);
  localparam logic [PairW-1:0] PairReset = PairW'(NODES * (NODES - 1) / 2);

  state_e state_q, state_d;

  logic [NodeW-1:0]   a_q, b_q;
  logic               bad_q;
  logic [NODES-1:0]   ra_q, rb_q;
  logic [NODES-1:0]   valid_q;
  logic [NcW-1:0]     i_q, cnt_a_q, cnt_b_q;
  logic [2*NcW-1:0]   drop_q;
  logic [PairW-1:0]   pair_q;

  logic [AW-1:0]      a_idx, b_idx, i_idx, row_idx;
  logic [NODES-1:0]   union_row, row_w;
  logic               accept, last_i;

  assign a_idx     = a_q[AW-1:0];
  assign b_idx     = b_q[AW-1:0];
  assign i_idx     = i_q[AW-1:0];
  assign union_row = ra_q | rb_q;
  assign accept    = (state_q == StIdle) && in_valid_i;
  assign last_i    = (i_q == cfg_i.node_count - NcW'(1));

  // rows never written since restart read as identity
  assign row_idx = (state_q == StRdB) ? a_idx : b_idx;
  assign row_w   = valid_q[row_idx] ? rd_data_i : (NODES'(1) << row_idx);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_valid_i) state_d = StRdB;
      StRdB:   state_d = StChk;
      StChk: begin
        if (bad_q || (a_q == b_q) || ra_q[b_idx]) begin
          state_d = StOut;
        end else begin
          state_d = StSweep;
        end
      end
      StSweep: if (last_i) state_d = StMul;
      StMul:   state_d = StUpd;
      StUpd:   state_d = StOut;
      StOut:   if (res_free_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_stall_o  = (state_q != StIdle);
    rd_en_o     = accept || (state_q == StRdB);
    rd_addr_o   = (state_q == StIdle) ? in_data_i.node_a[AW-1:0] : b_idx;
    wr_en_o     = (state_q == StSweep) && union_row[i_idx];
    wr_addr_o   = i_idx;
    wr_data_o   = union_row;
    res_valid_o = (state_q == StOut);
    res_o.disconnected_pairs = pair_q;
    res_o.bad_node           = bad_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= '0;
      pair_q  <= PairReset;
      i_q     <= '0;
      cnt_a_q <= '0;
      cnt_b_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_i.restart) begin
        valid_q <= '0;
        pair_q  <= cfg_i.pair_init;
      end else begin
        if (wr_en_o) begin
          valid_q[i_idx] <= 1'b1;
        end
        if (state_q == StUpd) begin
          if (drop_q > (2*NcW)'(pair_q)) begin
            pair_q <= '0;
          end else begin
            pair_q <= pair_q - drop_q[PairW-1:0];
          end
        end
      end
      if (state_q == StChk) begin
        i_q     <= '0;
        cnt_a_q <= '0;
        cnt_b_q <= '0;
      end else if (state_q == StSweep) begin
        i_q     <= i_q + NcW'(1);
        cnt_a_q <= cnt_a_q + NcW'(ra_q[i_idx]);
        cnt_b_q <= cnt_b_q + NcW'(rb_q[i_idx]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q   <= in_data_i.node_a;
      b_q   <= in_data_i.node_b;
      bad_q <= (NcW'(in_data_i.node_a) >= cfg_i.node_count) ||
               (NcW'(in_data_i.node_b) >= cfg_i.node_count);
    end
    if (state_q == StRdB) begin
      ra_q <= row_w;
    end
    if (state_q == StChk) begin
      rb_q <= row_w;
    end
    if (state_q == StMul) begin
      drop_q <= cnt_a_q * cnt_b_q;
    end
  end

endmodule

// ===== hw/rtl/incremental_connectivity_pair_count_unit.sv =====
// channel | dir | handshake          | payload
// in      | in  | in_valid_i/stall_o | item_in_t  node_a, node_b
// out     | out | out_valid_o/stall_i| item_out_t disconnected_pairs, bad_node
// cfg     | in  | cfg_we_i           | cfg_wdata_i node_count
//
// One transaction at a time: an ignored edge goes read, check, output; a merge also sweeps
// node_count rows through the dual-port reachability RAM, then multiplies and updates.
// Reset and node_count writes clear the row valid bits at once; no clearing pass.
// The output register frees the core while a result waits on out_stall_i.
module incremental_connectivity_pair_count_unit #(
  parameter int unsigned NODES = icpc_pkg::MaxNodes
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [icpc_pkg::NcW-1:0]       cfg_wdata_i,
  input  logic                           in_valid_i,
  input  icpc_pkg::item_in_t             in_data_i,
  output logic                           in_stall_o,
  output logic                           out_valid_o,
  output icpc_pkg::item_out_t            out_data_o,
  input  logic                           out_stall_i
);
  import icpc_pkg::*;

  localparam int unsigned AW = $clog2(NODES);

  logic [NcW-1:0] node_count_q;
  logic [NcW-1:0] nc_clamped;
  cfg_t           cfg;

  logic           res_valid, res_free;
  item_out_t      res;
  logic           out_valid_q;
  item_out_t      out_data_q;

  logic           rd_en, wr_en;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic [NODES-1:0] rd_data, wr_data;

  always_comb begin
    if (cfg_wdata_i < NcW'(2)) begin
      nc_clamped = NcW'(2);
    end else if (cfg_wdata_i > NcW'(NODES)) begin
      nc_clamped = NcW'(NODES);
    end else begin
      nc_clamped = cfg_wdata_i;
    end
  end

  assign cfg.restart    = cfg_we_i;
  assign cfg.node_count = node_count_q;
  assign cfg.pair_init  = pair_total(nc_clamped);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NcW'(NODES);
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= nc_clamped;
      end
      if (res_valid && res_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_free) begin
      out_data_q <= res;
    end
  end

  assign res_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  icpc_core #(
    .NODES(NODES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_free_i (res_free),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data)
  );

  icpc_ram #(
    .Width(NODES),
    .Depth(NODES)
  ) u_rows (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

endmodule

// ===== hw/rtl/icpc_checker.sv =====
module icpc_checker #(
  parameter int unsigned NODES = icpc_pkg::MaxNodes
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input icpc_pkg::item_out_t      out_data_o,
  input logic                     out_stall_i
);
  import icpc_pkg::*;

  localparam logic [PairW-1:0] PairMax = PairW'(NODES * (NODES - 1) / 2);

  // busy right after taking a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  // a result only appears at the end of a transaction in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without transaction in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.disconnected_pairs <= PairMax))
    else $error("pair count above maximum");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

bind incremental_connectivity_pair_count_unit icpc_checker #(.NODES(NODES)) u_checker (.*);

// ===== test/incremental_connectivity_pair_count_unit_test.sv =====
`timescale 1ns / 100ps

module incremental_connectivity_pair_count_unit_test;
  import icpc_pkg::*;

  typedef enum logic {
    RowEdge,
    RowCfg
  } row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [NcW-1:0]   nc_value;
    logic [NodeW-1:0] a;
    logic [NodeW-1:0] b;
    logic             typed;
    logic [PairW-1:0] pairs;
    logic             bad;
  } stim_row_t;

  localparam int NumRows = 26;
  localparam int NumSegs = 9;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           cfg_we_i = 1'b0;
  logic [NcW-1:0] cfg_wdata_i = '0;
  logic           in_valid_i = 1'b0;
  item_in_t       in_data_i = '0;
  logic           in_stall_o;
  logic           out_valid_o;
  item_out_t      out_data_o;
  logic           out_stall_i = 1'b0;

  logic [63:0]    reach_q [64];
  logic [11:0]    pairs_q;
  int unsigned    nc_q;
  item_out_t      pending_counts [$];
  int             n_errors = 0;
  int unsigned    send_idle_pct = 22;
  int unsigned    recv_idle_pct = 75;

  stim_row_t      dir_rows [NumRows];
  int unsigned    seg_nc [NumSegs] = '{64, 2, 9, 33, 0, 17, 127, 12, 100};
  int unsigned    seg_len [NumSegs] = '{150, 20, 40, 100, 10, 40, 100, 40, 20};

  incremental_connectivity_pair_count_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic note_mismatch(input string field, input int exp_v, input int got_v);
    $display("%0t: %s expected %0d got %0d", $time, field, exp_v, got_v);
    n_errors++;
  endtask

  function automatic void restart_rows(input logic [NcW-1:0] v);
    nc_q = v;
    if (nc_q < 2) nc_q = 2;
    if (nc_q > MaxNodes) nc_q = MaxNodes;
    for (int i = 0; i < 64; i++) reach_q[i] = 64'd1 << i;
    pairs_q = 12'((nc_q * (nc_q - 1)) / 2);
  endfunction

  function automatic item_out_t merge_edge(input item_in_t it);
    item_out_t   r;
    logic [63:0] u;
    int unsigned drop;
    r.bad_node = 1'b0;
    if (it.node_a >= nc_q || it.node_b >= nc_q) begin
      r.bad_node = 1'b1;
    end else if (it.node_a != it.node_b && !reach_q[it.node_a][it.node_b]) begin
      u = reach_q[it.node_a] | reach_q[it.node_b];
      drop = $countones(reach_q[it.node_a]) * $countones(reach_q[it.node_b]);
      for (int i = 0; i < 64; i++) begin
        if (i < nc_q && u[i]) reach_q[i] = u;
      end
      pairs_q = (drop > pairs_q) ? 12'd0 : pairs_q - 12'(drop);
    end
    r.disconnected_pairs = pairs_q[PairW-1:0];
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_edge(input item_in_t it, input logic typed, input item_out_t typed_res);
    item_out_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    r = merge_edge(it);
    pending_counts.push_back(typed ? typed_res : r);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_counts.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_node_count(input logic [NcW-1:0] v);
    drain_results();
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    restart_rows(v);
  endtask

  always @(posedge clk_i) begin
    item_out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_counts.size() == 0) begin
        note_mismatch("unexpected transaction, pairs", -1, out_data_o.disconnected_pairs);
      end else begin
        e = pending_counts.pop_front();
        if (out_data_o.disconnected_pairs !== e.disconnected_pairs)
          note_mismatch("disconnected_pairs", e.disconnected_pairs,
                        out_data_o.disconnected_pairs);
        if (out_data_o.bad_node !== e.bad_node)
          note_mismatch("bad_node", e.bad_node, out_data_o.bad_node);
      end
    end
  end

  initial begin
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    item_in_t    it;
    item_out_t   typed_res;
    int unsigned a;
    int unsigned b;
    int unsigned k;
    dir_rows = '{
      '{RowEdge, 7'd0,   6'd0,  6'd0,  1'b1, 11'd2016, 1'b0},
      '{RowEdge, 7'd0,   6'd63, 6'd0,  1'b1, 11'd2015, 1'b0},
      '{RowEdge, 7'd0,   6'd0,  6'd63, 1'b1, 11'd2015, 1'b0},
      '{RowEdge, 7'd0,   6'd1,  6'd2,  1'b1, 11'd2014, 1'b0},
      '{RowEdge, 7'd0,   6'd2,  6'd63, 1'b0, 11'd0,    1'b0},
      '{RowEdge, 7'd0,   6'd63, 6'd1,  1'b0, 11'd0,    1'b0},
      '{RowEdge, 7'd0,   6'd42, 6'd21, 1'b0, 11'd0,    1'b0},
      '{RowCfg,  7'd0,   6'd0,  6'd0,  1'b0, 11'd0,    1'b0},
      '{RowEdge, 7'd0,   6'd0,  6'd1,  1'b1, 11'd0,    1'b0},
      '{RowEdge, 7'd0,   6'd1,  6'd0,  1'b1, 11'd0,    1'b0},
      '{RowEdge, 7'd0,   6'd2,  6'd0,  1'b1, 11'd0,    1'b1},
      '{RowEdge, 7'd0,   6'd63, 6'd63, 1'b1, 11'd0,    1'b1},
      '{RowCfg,  7'd127, 6'd0,  6'd0,  1'b0, 11'd0,    1'b0},
      '{RowEdge, 7'd0,   6'd63, 6'd62, 1'b1, 11'd2015, 1'b0},
      '{RowCfg,  7'd5,   6'd0,  6'd0,  1'b0, 11'd0,    1'b0},
      '{RowEdge, 7'd0,   6'd4,  6'd5,  1'b1, 11'd10,   1'b1},
      '{RowEdge, 7'd0,   6'd5,  6'd4,  1'b1, 11'd10,   1'b1},
      '{RowEdge, 7'd0,   6'd0,  6'd4,  1'b1, 11'd9,    1'b0},
      '{RowEdge, 7'd0,   6'd1,  6'd2,  1'b0, 11'd0,    1'b0},
      '{RowEdge, 7'd0,   6'd3,  6'd4,  1'b0, 11'd0,    1'b0},
      '{RowEdge, 7'd0,   6'd1,  6'd3,  1'b0, 11'd0,    1'b0},
      '{RowEdge, 7'd0,   6'd4,  6'd2,  1'b0, 11'd0,    1'b0},
      '{RowCfg,  7'd1,   6'd0,  6'd0,  1'b0, 11'd0,    1'b0},
      '{RowEdge, 7'd0,   6'd1,  6'd1,  1'b1, 11'd1,    1'b0},
      '{RowEdge, 7'd0,   6'd0,  6'd1,  1'b1, 11'd0,    1'b0},
      '{RowCfg,  7'd64,  6'd0,  6'd0,  1'b0, 11'd0,    1'b0}
    };
    restart_rows(7'd64);
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowCfg) begin
        write_node_count(dir_rows[i].nc_value);
      end else begin
        it.node_a = dir_rows[i].a;
        it.node_b = dir_rows[i].b;
        typed_res.disconnected_pairs = dir_rows[i].pairs;
        typed_res.bad_node = dir_rows[i].bad;
        send_edge(it, dir_rows[i].typed, typed_res);
      end
    end

    typed_res = '0;
    for (int s = 0; s < NumSegs; s++) begin
      if (s == 3) begin
        send_idle_pct = 75;
        recv_idle_pct = 22;
      end else if (s == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_node_count(NcW'(seg_nc[s]));
      for (k = 0; k < seg_len[s]; k++) begin
        if ($urandom_range(9) == 0) begin
          a = $urandom_range(63);
          b = $urandom_range(63);
        end else begin
          a = $urandom_range(nc_q - 1);
          b = ($urandom_range(7) == 0) ? a : $urandom_range(nc_q - 1);
        end
        it.node_a = NodeW'(a);
        it.node_b = NodeW'(b);
        send_edge(it, 1'b0, typed_res);
        // hold off until the block is empty now and then
        if (k % 50 == 49) drain_results();
      end
    end

    drain_results();
    repeat (80) @(negedge clk_i);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
